// ----- rtl/core/md5_byte_stream_hasher_macros.svh -----
// Assertion macros for the MD5 byte stream hasher.
// No dependencies; included by modules that carry assertions.
`ifndef MD5_BYTE_STREAM_HASHER_MACROS_SVH
`define MD5_BYTE_STREAM_HASHER_MACROS_SVH
`ifndef SYNTHESIS
`define MD5_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MD5_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MD5_ASSERT_IMP(label, clk, rst, ante, cons)
`define MD5_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/md5_pkg.sv -----
// Package for the MD5 byte stream hasher: constants, state type, round tables.
// No dependencies.
`timescale 1ns / 1ps
package md5_pkg;
   localparam int unsigned BlockBytes = 64;
   localparam logic [31:0] InitA = 32'h67452301;
   localparam logic [31:0] InitB = 32'hefcdab89;
   localparam logic [31:0] InitC = 32'h98badcfe;
   localparam logic [31:0] InitD = 32'h10325476;
   localparam logic [7:0]  PadByte = 8'h80;
   localparam logic [5:0]  LenOffset = 6'd56;
   localparam logic        FuncAbsorb = 1'b0;
   localparam logic        FuncFinish = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMP,
      ST_ADD,
      ST_OUT
   } state_type;

   // Control from sequencer to compression unit.
   typedef struct packed {
      logic start;
      logic finish_add;
   } comp_ctl_type;

   typedef struct packed {
      logic busy;
      logic [5:0] rd_addr_msb; // byte address of the word being read (4*word)
   } comp_sts_type;

   function automatic logic [31:0] step_const(input logic [5:0] k);
      logic [31:0] t [64];
      t = '{
         32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
         32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
         32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
         32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
         32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
         32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
         32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
         32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
         32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
         32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
         32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
         32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
         32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
         32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
         32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
         32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      return t[k];
   endfunction

   function automatic logic [4:0] step_rot(input logic [5:0] k);
      logic [4:0] r;
      case ({k[5:4], k[1:0]})
         4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
         4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
         4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
         4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
      endcase
      return r;
   endfunction

   // Message word index for step k.
   function automatic logic [3:0] msg_index(input logic [5:0] k);
      logic [3:0] g;
      case (k[5:4])
         2'd0: g = k[3:0];
         2'd1: g = 4'(5 * k[3:0] + 1);
         2'd2: g = 4'(3 * k[3:0] + 5);
         default: g = 4'(7 * k[3:0]);
      endcase
      return g;
   endfunction
endpackage

// ----- rtl/core/md5_compress.sv -----
// MD5 compression unit: one step per cycle, reads message words from a
// 16x32 word memory through a registered read port. Depends on md5_pkg.
`timescale 1ns / 1ps
`include "md5_byte_stream_hasher_macros.svh"
module md5_compress (
   input  logic                 clock,
   input  logic                 reset,
   input  md5_pkg::comp_ctl_type ctl,
   input  logic [31:0]          chain_in [4],
   output logic [31:0]          chain_out [4],
   output md5_pkg::comp_sts_type sts,
   // message word write port (from byte packer)
   input  logic                 wr_en,
   input  logic [3:0]           wr_addr,
   input  logic [31:0]          wr_data
);
   logic [31:0] msg_mem [16];
   logic [31:0] rd_data_ff;
   logic [3:0]  rd_addr;
   logic [6:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [31:0] f, t, rot;
   logic [5:0]  k;
   logic        run;

   // step_ff counts 0..65: step_ff reads the word for its step; that step executes in the next cycle.
   assign rd_addr = md5_pkg::msg_index(step_ff[5:0]);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         msg_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= msg_mem[rd_addr];
   end

   assign k   = 6'(step_ff - 7'd1);
   assign run = busy_ff && (step_ff != 7'd0);

   always_comb begin
      case (k[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      t   = a_ff + f + rd_data_ff + md5_pkg::step_const(k);
      rot = (t << md5_pkg::step_rot(k)) | (t >> (6'd32 - {1'b0, md5_pkg::step_rot(k)}));
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         step_in = 7'd0;
         a_in = chain_in[0]; b_in = chain_in[1];
         c_in = chain_in[2]; d_in = chain_in[3];
      end else if (busy_ff) begin
         step_in = step_ff + 7'd1;
         if (run) begin
            a_in = d_ff; d_in = c_ff; c_in = b_ff; b_in = b_ff + rot;
         end
         if (step_ff == 7'd64) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
   end

   always_comb begin
      chain_out[0] = chain_in[0] + a_ff;
      chain_out[1] = chain_in[1] + b_ff;
      chain_out[2] = chain_in[2] + c_ff;
      chain_out[3] = chain_in[3] + d_ff;
   end

   assign sts.busy = busy_ff;
   assign sts.rd_addr_msb = {rd_addr, 2'b00};

   `MD5_ASSERT_IMP(a_no_write_busy, clock, reset, busy_ff, !wr_en)
   `MD5_ASSERT_NXT(a_start_busy, clock, reset, ctl.start, busy_ff && step_ff == 7'd0)
   `MD5_ASSERT_IMP(a_no_add_busy, clock, reset, ctl.finish_add, !busy_ff)
endmodule

// ----- rtl/core/md5_byte_stream_hasher.sv -----
// Top level of the MD5 byte stream hasher: sequencer, byte packer, chaining
// registers and digest output. Depends on md5_pkg and md5_compress.
`timescale 1ns / 1ps
`include "md5_byte_stream_hasher_macros.svh"
// MD5 hasher fed one message byte per transaction (req_func = 0) and closed
// by a finish transaction (req_func = 1), which returns 16 digest bytes on the
// rsp channel, low byte of word A first, rsp_last_byte on the sixteenth; the
// context then restarts for a new message. A data byte leaves the hasher idle
// unless it fills the 64-byte block, which then runs the compression unit:
// a one-cycle start pulse, word reads and MD5 steps from a 16-word message
// memory, then leaving the compression state and adding into the chaining
// words, before the next transaction is taken.
// Finish writes padding one byte per cycle (64 minus the fill, up to 64
// bytes), one compression, or a second 64-byte padding pass and compression
// when the fill was 56 or more, then the 16 digest bytes, each held until
// rsp_ready. Bytes are packed into 32-bit words before the memory write, so the
// block buffer needs no clearing.
module md5_byte_stream_hasher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_digest_byte,
   output logic       rsp_last_byte
);
   md5_pkg::state_type    state_ff, state_in;
   md5_pkg::comp_ctl_type ctl;
   md5_pkg::comp_sts_type sts;

   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] chain_new [4];
   logic [63:0] bits_ff, bits_in, len_ff, len_in;
   logic [5:0]  fill_ff, fill_in;
   logic [23:0] pack_ff, pack_in;     // low three bytes of current word
   logic        pad_first_ff, pad_first_in;
   logic        final_ff, final_in;   // current compression is the last one
   logic        padding_ff, padding_in; // finish in progress
   logic [3:0]  out_ff, out_in;
   logic        wr_en;
   logic [3:0]  wr_addr;
   logic [31:0] wr_data;
   logic        put;
   logic [7:0]  put_byte;
   logic        accept;
   logic [7:0]  len_byte;
   logic        comp_started_ff;

   md5_compress u_comp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .chain_in  (chain_ff),
      .chain_out (chain_new),
      .sts       (sts),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   assign accept = req_valid && req_ready;
   assign len_byte = 8'(len_ff >> {fill_ff[2:0], 3'b000});

   // Byte selection for the packer.
   always_comb begin
      put = 1'b0;
      put_byte = req_data_byte;
      if (state_ff == md5_pkg::ST_IDLE) begin
         put = accept && (req_func == md5_pkg::FuncAbsorb);
      end else if (state_ff == md5_pkg::ST_PAD) begin
         put = 1'b1;
         if (pad_first_ff) begin
            put_byte = md5_pkg::PadByte;
         end else if (final_ff && fill_ff >= md5_pkg::LenOffset) begin
            put_byte = len_byte;
         end else begin
            put_byte = 8'h00;
         end
      end
   end

   assign wr_en   = put && (fill_ff[1:0] == 2'b11);
   assign wr_addr = fill_ff[5:2];
   assign wr_data = {put_byte, pack_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         md5_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_func == md5_pkg::FuncFinish) begin
                  state_in = md5_pkg::ST_PAD;
               end else if (fill_ff == 6'd63) begin
                  state_in = md5_pkg::ST_COMP;
               end
            end
         end
         md5_pkg::ST_PAD: begin
            if (fill_ff == 6'd63) begin
               state_in = md5_pkg::ST_COMP;
            end
         end
         md5_pkg::ST_COMP: begin
            if (!sts.busy && !ctl.start) begin
               state_in = md5_pkg::ST_ADD;
            end
         end
         md5_pkg::ST_ADD: begin
            // length block done -> digest; padding spilled -> second pass
            if (final_ff) begin
               state_in = md5_pkg::ST_OUT;
            end else if (padding_ff) begin
               state_in = md5_pkg::ST_PAD;
            end else begin
               state_in = md5_pkg::ST_IDLE;
            end
         end
         md5_pkg::ST_OUT: begin
            if (rsp_ready && out_ff == 4'd15) begin
               state_in = md5_pkg::ST_IDLE;
            end
         end
         default: state_in = md5_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath updates.
   always_comb begin
      req_ready = (state_ff == md5_pkg::ST_IDLE);
      rsp_valid = (state_ff == md5_pkg::ST_OUT);
      rsp_digest_byte = 8'(chain_ff[out_ff[3:2]] >> {out_ff[1:0], 3'b000});
      rsp_last_byte = (out_ff == 4'd15);
      ctl.start = (state_ff == md5_pkg::ST_COMP) && !comp_started_ff;
      ctl.finish_add = (state_ff == md5_pkg::ST_ADD);

      fill_in = fill_ff;
      pack_in = pack_ff;
      bits_in = bits_ff;
      len_in = len_ff;
      pad_first_in = pad_first_ff;
      final_in = final_ff;
      padding_in = padding_ff;
      out_in = out_ff;
      chain_in = chain_ff;

      if (put) begin
         fill_in = fill_ff + 6'd1;
         pack_in = {put_byte, pack_ff[23:8]};
      end
      if (state_ff == md5_pkg::ST_IDLE && accept) begin
         if (req_func == md5_pkg::FuncAbsorb) begin
            bits_in = bits_ff + 64'd8;
         end else begin
            len_in = bits_ff;
            pad_first_in = 1'b1;
            final_in = 1'b0;
            padding_in = 1'b1;
         end
      end
      if (state_ff == md5_pkg::ST_PAD) begin
         pad_first_in = 1'b0;
         // length fits in this block when padding reaches offset 56
         if (fill_ff == md5_pkg::LenOffset - 6'd1) begin
            final_in = 1'b1;
         end
      end
      if (state_ff == md5_pkg::ST_ADD) begin
         chain_in = chain_new;
         if (final_ff) begin
            out_in = 4'd0;
         end
      end
      if (state_ff == md5_pkg::ST_OUT && rsp_ready) begin
         out_in = out_ff + 4'd1;
         if (out_ff == 4'd15) begin
            chain_in[0] = md5_pkg::InitA;
            chain_in[1] = md5_pkg::InitB;
            chain_in[2] = md5_pkg::InitC;
            chain_in[3] = md5_pkg::InitD;
            bits_in = '0;
            fill_in = '0;
            final_in = 1'b0;
            padding_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= md5_pkg::ST_IDLE;
         fill_ff <= '0;
         bits_ff <= '0;
         pad_first_ff <= 1'b0;
         final_ff <= 1'b0;
         padding_ff <= 1'b0;
         out_ff <= '0;
         comp_started_ff <= 1'b0;
         chain_ff[0] <= md5_pkg::InitA;
         chain_ff[1] <= md5_pkg::InitB;
         chain_ff[2] <= md5_pkg::InitC;
         chain_ff[3] <= md5_pkg::InitD;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         bits_ff <= bits_in;
         pad_first_ff <= pad_first_in;
         final_ff <= final_in;
         padding_ff <= padding_in;
         out_ff <= out_in;
         comp_started_ff <= (state_ff == md5_pkg::ST_COMP);
         chain_ff <= chain_in;
      end
      pack_ff <= pack_in;
      len_ff <= len_in;
   end

   `MD5_ASSERT_IMP(a_one_side, clock, reset, 1'b1, !(req_ready && rsp_valid))
   `MD5_ASSERT_IMP(a_out_block, clock, reset, rsp_valid, fill_ff == 6'd0 && !sts.busy)
   `MD5_ASSERT_NXT(a_last_done, clock, reset, rsp_valid && rsp_ready && rsp_last_byte, req_ready)
endmodule
